FILE: design/dtmf_pkg.sv
// ----------------------------------------------------------------------------
// dtmf_pkg
// Shared types, field widths and default constants of the DTMF tone generator.
// ----------------------------------------------------------------------------
package dtmf_pkg;

	// Field widths
	localparam int AMP_W      = 14;
	localparam int LEN_W      = 12;
	localparam int CODE_W     = 8;
	localparam int SAMPLE_W   = 16;
	localparam int SINE_W     = 15;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	// Default parameter values
	localparam int PHASE_BITS_DEF       = 32;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int SAMPLE_RATE_DEF      = 8000;

	// Register reset values
	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(10000);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(800);

	// Request kinds
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} dtmf_cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE   = 1'b0,
		REG_TONE_LENGTH = 1'b1
	} dtmf_reg_t;

	// Tone status from the controller
	typedef struct packed {
		logic playing;
		logic last;
	} dtmf_status_t;

endpackage

FILE: design/dtmf_tone_generator_unit.sv
// ----------------------------------------------------------------------------
// dtmf_tone_generator_unit
// A tick request passes through the input register, then the result register.
// Throughput: one request per cycle while samples are taken, set by the single-pass
// path from phase registers through sine table, amplitude multiplier and final add.
// Reset: amplitude 10000, tone_length 800, tone idle, both pipeline stages empty.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_unit import dtmf_pkg::*; #(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int SAMPLE_RATE      = SAMPLE_RATE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic [CODE_W-1:0]          event_code,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       active,
	output logic                       last
);

	logic [AMP_W-1:0] amplitude_q;
	logic [LEN_W-1:0] tone_length_q;

	logic              valid_s1;
	dtmf_cmd_t         cmd_s1;
	logic [CODE_W-1:0] code_s1;

	logic                       valid_s2;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic                       active_s2;
	logic                       last_s2;

	logic s1_go;
	logic start_go;
	logic tick_go;
	logic in_take;

	logic [PHASE_BITS-1:0]      low_phase;
	logic [PHASE_BITS-1:0]      high_phase;
	dtmf_status_t               status;
	logic signed [SINE_W-1:0]   low_term;
	logic signed [SINE_W-1:0]   high_term;
	logic signed [SAMPLE_W-1:0] tone_sum;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q   <= AMP_RESET;
			tone_length_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			case (dtmf_reg_t'(cfg_index))
				REG_AMPLITUDE:   amplitude_q   <= cfg_data[AMP_W-1:0];
				REG_TONE_LENGTH: tone_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 drains unless a tick would overwrite an untaken sample
	assign s1_go    = valid_s1 && ((cmd_s1 == CMD_START) || !valid_s2 || out_ready);
	assign start_go = s1_go && (cmd_s1 == CMD_START);
	assign tick_go  = s1_go && (cmd_s1 == CMD_TICK);
	assign in_ready = !valid_s1 || s1_go;
	assign in_take  = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1  <= dtmf_cmd_t'(command);
			code_s1 <= event_code;
		end
	end

	dtmf_tone_ctrl #(
		.PHASE_BITS (PHASE_BITS),
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_en   (start_go),
		.tick_en    (tick_go),
		.code       (code_s1),
		.tone_length(tone_length_q),
		.low_phase  (low_phase),
		.high_phase (high_phase),
		.status     (status)
	);

	dtmf_tone_term #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_low_term (
		.phase    (low_phase),
		.amplitude(amplitude_q),
		.term     (low_term)
	);

	dtmf_tone_term #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_high_term (
		.phase    (high_phase),
		.amplitude(amplitude_q),
		.term     (high_term)
	);

	// Add the row and column tones
	assign tone_sum = SAMPLE_W'(low_term) + SAMPLE_W'(high_term);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (tick_go) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			sample_s2 <= status.playing ? tone_sum : '0;
			active_s2 <= status.playing;
			last_s2   <= status.playing && status.last;
		end
	end

	assign out_valid = valid_s2;
	assign sample    = sample_s2;
	assign active    = active_s2;
	assign last      = last_s2;

`ifndef NO_ASSERTIONS
	// An idle tick reports silence
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !active_s2 |-> (sample_s2 == '0) && !last_s2)
		else $error("idle sample is not zero");

	// The final sample of a tone leaves the generator idle
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go && status.playing && status.last && !start_go |=> !status.playing)
		else $error("tone kept playing after its last sample");

	// A held stage 1 request blocks new input
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |-> !in_ready)
		else $error("input taken while stage 1 is held");

	// A tick taken by stage 2 always presents a result next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> valid_s2)
		else $error("tick did not produce a result");
`endif

endmodule

FILE: design/dtmf_sine_lut.sv
// ----------------------------------------------------------------------------
// dtmf_sine_lut
// Quarter-wave sine table in Q0.15, folded out to a full period.
// ----------------------------------------------------------------------------
module dtmf_sine_lut import dtmf_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] index,
	output logic [SINE_W-1:0]                   magnitude,
	output logic                                negative
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int QD_W  = IDX_W - 2;
	localparam int QD    = SINE_TABLE_DEPTH / 4;

	localparam longint HALF_PI_Q28  = 64'sd421657428;
	localparam longint Q28_ONE_HALF = 64'sd134217728;
	localparam longint SINE_MAX     = 64'sd32767;

	// sin(a*(pi/2)/DEPTH) in Q0.15 by a Q28 Taylor series through x^15
	function automatic logic [SINE_W-1:0] quarter_sine(input longint a);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint q;
		x    = (a * HALF_PI_Q28 + longint'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
		x2   = (x * x) >>> 28;
		term = ((x * x2) >>> 28) / 6;
		sum  = x - term;
		term = ((term * x2) >>> 28) / 20;
		sum  = sum + term;
		term = ((term * x2) >>> 28) / 42;
		sum  = sum - term;
		term = ((term * x2) >>> 28) / 72;
		sum  = sum + term;
		term = ((term * x2) >>> 28) / 110;
		sum  = sum - term;
		term = ((term * x2) >>> 28) / 156;
		sum  = sum + term;
		term = ((term * x2) >>> 28) / 210;
		sum  = sum - term;
		if (sum < 0) begin
			sum = 0;
		end
		q = (sum * SINE_MAX + Q28_ONE_HALF) >>> 28;
		if (q > SINE_MAX) begin
			q = SINE_MAX;
		end
		return q[SINE_W-1:0];
	endfunction

	// Value at the quarter-wave peak
	localparam logic [SINE_W-1:0] SINE_PEAK = quarter_sine(longint'(SINE_TABLE_DEPTH));

	logic [SINE_W-1:0] qtab [QD];

	// Build the quarter-wave table, one entry per step of four
	for (genvar j = 0; j < QD; j++) begin : g_tab
		localparam logic [SINE_W-1:0] ENTRY = quarter_sine(longint'(4 * j));
		assign qtab[j] = ENTRY;
	end

	logic [1:0]      quad;
	logic [QD_W-1:0] low;
	logic [QD_W-1:0] mirror;

	assign quad   = index[IDX_W-1 -: 2];
	assign low    = index[QD_W-1:0];
	assign mirror = QD_W'(0) - low;

	// Fold the index into the first quarter and mirror on odd quarters
	always_comb begin
		if (!quad[0]) begin
			magnitude = qtab[low];
		end else if (low == '0) begin
			magnitude = SINE_PEAK;
		end else begin
			magnitude = qtab[mirror];
		end
	end

	assign negative = quad[1];

endmodule

FILE: design/dtmf_tone_term.sv
// ----------------------------------------------------------------------------
// dtmf_tone_term
// One sine component: table lookup on the phase, scaled by the amplitude.
// ----------------------------------------------------------------------------
module dtmf_tone_term import dtmf_pkg::*; #(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic [PHASE_BITS-1:0]   phase,
	input  logic [AMP_W-1:0]        amplitude,
	output logic signed [SINE_W-1:0] term
);

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int PROD_W = AMP_W + SINE_W;

	logic [SINE_W-1:0] magnitude;
	logic              negative;
	logic [PROD_W-1:0] product;
	logic [AMP_W-1:0]  scaled;

	dtmf_sine_lut #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_lut (
		.index    (phase[PHASE_BITS-1 -: IDX_W]),
		.magnitude(magnitude),
		.negative (negative)
	);

	// Scale and truncate toward zero
	assign product = PROD_W'(amplitude) * PROD_W'(magnitude);
	assign scaled  = product[PROD_W-1 -: AMP_W];

	// Apply the sign of the half-wave
	always_comb begin
		if (negative) begin
			term = -$signed({1'b0, scaled});
		end else begin
			term = $signed({1'b0, scaled});
		end
	end

endmodule

FILE: design/dtmf_tone_ctrl.sv
// ----------------------------------------------------------------------------
// dtmf_tone_ctrl
// Digit decode, phase accumulators and the remaining sample count of a tone.
// ----------------------------------------------------------------------------
module dtmf_tone_ctrl import dtmf_pkg::*; #(
	parameter int PHASE_BITS  = PHASE_BITS_DEF,
	parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start_en,
	input  logic                  tick_en,
	input  logic [CODE_W-1:0]     code,
	input  logic [LEN_W-1:0]      tone_length,
	output logic [PHASE_BITS-1:0] low_phase,
	output logic [PHASE_BITS-1:0] high_phase,
	output dtmf_status_t          status
);

	// Phase step of round(hz * 2^PHASE_BITS / SAMPLE_RATE)
	function automatic logic [PHASE_BITS-1:0] phase_inc(input longint hz);
		longint num;
		num = ((hz <<< PHASE_BITS) + longint'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
		return num[PHASE_BITS-1:0];
	endfunction

	localparam logic [PHASE_BITS-1:0] ROW_INC [4] = '{
		phase_inc(697), phase_inc(770), phase_inc(852), phase_inc(941)
	};
	localparam logic [PHASE_BITS-1:0] COL_INC [4] = '{
		phase_inc(1209), phase_inc(1336), phase_inc(1477), phase_inc(1633)
	};

	logic [PHASE_BITS-1:0] low_phase_q;
	logic [PHASE_BITS-1:0] high_phase_q;
	logic [1:0]            row_q;
	logic [1:0]            col_q;
	logic [LEN_W-1:0]      samples_left_q;
	logic                  playing_q;

	logic       code_valid;
	logic [1:0] row_dec;
	logic [1:0] col_dec;

	assign code_valid = (code[CODE_W-1:4] == '0);

	// Map an event code to its keypad row and column
	always_comb begin
		case (code[3:0])
			4'd0:    begin row_dec = 2'd3; col_dec = 2'd1; end
			4'd1:    begin row_dec = 2'd0; col_dec = 2'd0; end
			4'd2:    begin row_dec = 2'd0; col_dec = 2'd1; end
			4'd3:    begin row_dec = 2'd0; col_dec = 2'd2; end
			4'd4:    begin row_dec = 2'd1; col_dec = 2'd0; end
			4'd5:    begin row_dec = 2'd1; col_dec = 2'd1; end
			4'd6:    begin row_dec = 2'd1; col_dec = 2'd2; end
			4'd7:    begin row_dec = 2'd2; col_dec = 2'd0; end
			4'd8:    begin row_dec = 2'd2; col_dec = 2'd1; end
			4'd9:    begin row_dec = 2'd2; col_dec = 2'd2; end
			4'd10:   begin row_dec = 2'd3; col_dec = 2'd0; end
			4'd11:   begin row_dec = 2'd3; col_dec = 2'd2; end
			4'd12:   begin row_dec = 2'd0; col_dec = 2'd3; end
			4'd13:   begin row_dec = 2'd1; col_dec = 2'd3; end
			4'd14:   begin row_dec = 2'd2; col_dec = 2'd3; end
			default: begin row_dec = 2'd3; col_dec = 2'd3; end
		endcase
	end

	// Restart on a valid start request, advance on each playing tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_phase_q    <= '0;
			high_phase_q   <= '0;
			row_q          <= '0;
			col_q          <= '0;
			samples_left_q <= '0;
			playing_q      <= 1'b0;
		end else if (start_en && code_valid) begin
			low_phase_q    <= '0;
			high_phase_q   <= '0;
			row_q          <= row_dec;
			col_q          <= col_dec;
			samples_left_q <= tone_length;
			playing_q      <= (tone_length != '0);
		end else if (tick_en && playing_q) begin
			low_phase_q    <= low_phase_q + ROW_INC[row_q];
			high_phase_q   <= high_phase_q + COL_INC[col_q];
			samples_left_q <= samples_left_q - LEN_W'(1);
			if (samples_left_q == LEN_W'(1)) begin
				playing_q <= 1'b0;
			end
		end
	end

	assign low_phase      = low_phase_q;
	assign high_phase     = high_phase_q;
	assign status.playing = playing_q;
	assign status.last    = (samples_left_q == LEN_W'(1));

endmodule
